/* design/dfr_pkg.sv */
// Shared types and constants for the length-framed packet deframer.
// No dependencies; imported by every module of the block.

package dfr_pkg;

    // Frames reported for one received byte, at most.
    localparam int unsigned MAX_RESULTS = 42;
    localparam int unsigned RES_CW      = 6;

    // Input queue between the front and the scan engine.
    localparam int unsigned RXQ_DEPTH = 4;
    localparam int unsigned RXQ_AW    = 2;

    // Configuration port.
    localparam int unsigned CFG_IW = 2;
    localparam int unsigned CFG_DW = 8;

    localparam logic [7:0] START_MARKER_RST = 8'd9;
    localparam logic [7:0] END_MARKER_RST   = 8'd10;
    localparam logic [7:0] MAX_LEN_RST      = 8'd100;

    typedef enum logic [CFG_IW-1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_MAX_LEN      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] max_len;
        logic       start_wr;     // start marker was just rewritten
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rxq_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_CHK,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_END_CHK,
        ST_EMIT,
        ST_DONE
    } scan_state_t;

endpackage

/* design/dfr_cfg.sv */
// Configuration register file of the deframer: markers and length limit.
// Depends on dfr_pkg.

module dfr_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dfr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DW-1:0]  cfg_data,
    output dfr_pkg::cfg_t               cfg
);
    import dfr_pkg::*;

    logic [7:0] start_reg, start_next;
    logic [7:0] end_reg,   end_next;
    logic [7:0] max_reg,   max_next;
    logic       start_wr;
    logic       wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        max_next   = max_reg;
        start_wr   = 1'b0;
        if (wr) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_START_MARKER: begin
                    start_next = cfg_data;
                    start_wr   = 1'b1;
                end
                REG_END_MARKER: end_next = cfg_data;
                REG_MAX_LEN:    max_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_MARKER_RST;
            end_reg   <= END_MARKER_RST;
            max_reg   <= MAX_LEN_RST;
        end else begin
            start_reg <= start_next;
            end_reg   <= end_next;
            max_reg   <= max_next;
        end
    end

    assign cfg.start_marker = start_reg;
    assign cfg.end_marker   = end_reg;
    assign cfg.max_len      = max_reg;
    assign cfg.start_wr     = start_wr;

endmodule

/* design/dfr_front.sv */
// Front of the deframer: takes received bytes off the input stream into a
// small queue that the scan engine drains. Depends on dfr_pkg.

module dfr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    output dfr_pkg::rxq_t rxq,
    input  logic          rxq_pop
);
    import dfr_pkg::*;

    logic [7:0]        q_reg [RXQ_DEPTH];
    logic [RXQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RXQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RXQ_AW:0]   cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign s_axis_tready = (cnt_reg != (RXQ_AW+1)'(RXQ_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = rxq_pop && rxq.valid;

    assign rxq.valid = (cnt_reg != '0);
    assign rxq.data  = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* design/dfr_back.sv */
// Scan engine of the deframer: circular byte store, frame search sequencer,
// held-back result for the last-frame flag, and the output register.
// Depends on dfr_pkg.

module dfr_back #(
    parameter int unsigned BUFFER_BYTES = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  dfr_pkg::cfg_t cfg,
    input  dfr_pkg::rxq_t rxq,
    output logic          rxq_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // [7:0] frame_type, [15:8] payload_length
    output logic          m_axis_tlast    // last_frame
);
    import dfr_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned XW = (CW > 10) ? CW : 10;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW+1)'(BUFFER_BYTES)) begin
            sum = sum - (CW+1)'(BUFFER_BYTES);
        end
        return sum[AW-1:0];
    endfunction

    logic [7:0]    byte_store [BUFFER_BYTES];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    scan_state_t       state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     fill_reg, fill_next;
    // leading bytes already known not to be a start marker
    logic [CW-1:0]     clean_reg, clean_next;
    logic [7:0]        len_reg, len_next;
    logic [RES_CW-1:0] res_cnt_reg, res_cnt_next;

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_type_reg, pend_type_next;
    logic [7:0] pend_len_reg, pend_len_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_type_reg, out_type_next;
    logic [7:0] out_len_reg, out_len_next;
    logic       out_last_reg, out_last_next;

    logic          out_free;
    logic [XW-1:0] len_p2_x;
    logic [XW-1:0] len_p3_x;
    logic [CW-1:0] len_p2;
    logic [CW-1:0] len_p3;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign len_p2_x = XW'(rd_data_reg) + XW'(2);
    assign len_p2   = len_p2_x[CW-1:0];
    assign len_p3_x = XW'(len_reg) + XW'(3);
    assign len_p3   = len_p3_x[CW-1:0];

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        clean_next      = clean_reg;
        len_next        = len_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_type_next  = pend_type_reg;
        pend_len_next   = pend_len_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_type_next   = out_type_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        wr_addr         = head_reg;
        rd_addr         = head_reg;
        rxq_pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (rxq.valid) begin
                    rxq_pop      = 1'b1;
                    mem_we       = 1'b1;
                    res_cnt_next = '0;
                    if (fill_reg == CW'(BUFFER_BYTES)) begin
                        // full: new byte overwrites the oldest
                        wr_addr   = head_reg;
                        head_next = wrap_add(head_reg, CW'(1));
                        if (clean_reg != '0) begin
                            clean_next = clean_reg - 1'b1;
                        end
                    end else begin
                        wr_addr   = wrap_add(head_reg, fill_reg);
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (clean_reg >= fill_reg) begin
                    state_next = ST_DONE;     // no start marker, keep all
                end else begin
                    mem_re     = 1'b1;
                    rd_addr    = wrap_add(head_reg, clean_reg);
                    state_next = ST_SEARCH_CHK;
                end
            end
            ST_SEARCH_CHK: begin
                if (rd_data_reg == cfg.start_marker) begin
                    head_next  = wrap_add(head_reg, clean_reg);
                    fill_next  = fill_reg - clean_reg;
                    clean_next = '0;
                    state_next = ST_LEN_RD;
                end else begin
                    clean_next = clean_reg + 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_LEN_RD: begin
                if (fill_reg < CW'(2)) begin
                    state_next = ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    rd_addr    = wrap_add(head_reg, CW'(1));
                    state_next = ST_LEN_CHK;
                end
            end
            ST_LEN_CHK: begin
                len_next = rd_data_reg;
                if (rd_data_reg > cfg.max_len) begin
                    head_next  = wrap_add(head_reg, CW'(1));
                    fill_next  = fill_reg - 1'b1;
                    clean_next = '0;
                    state_next = ST_SEARCH;
                end else if (XW'(rd_data_reg) + XW'(3) > XW'(fill_reg)) begin
                    state_next = ST_DONE;     // frame not complete yet
                end else begin
                    mem_re     = 1'b1;
                    rd_addr    = wrap_add(head_reg, len_p2);
                    state_next = ST_END_CHK;
                end
            end
            ST_END_CHK: begin
                if (rd_data_reg != cfg.end_marker) begin
                    head_next  = wrap_add(head_reg, CW'(1));
                    fill_next  = fill_reg - 1'b1;
                    clean_next = '0;
                    state_next = ST_SEARCH;
                end else begin
                    mem_re     = 1'b1;
                    rd_addr    = wrap_add(head_reg, CW'(2));
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // rd_data_reg holds the type byte until the held result moves on
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_type_next  = pend_type_reg;
                        out_len_next   = pend_len_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_type_next  = rd_data_reg;
                    pend_len_next   = len_reg;
                    head_next       = wrap_add(head_reg, len_p3);
                    fill_next       = fill_reg - len_p3;
                    clean_next      = '0;
                    res_cnt_next    = res_cnt_reg + 1'b1;
                    if (res_cnt_reg == RES_CW'(MAX_RESULTS - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_type_next   = pend_type_reg;
                    out_len_next    = pend_len_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg.start_wr) begin
            clean_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            byte_store[wr_addr] <= rxq.data;
        end
        if (mem_re) begin
            rd_data_reg <= byte_store[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            clean_reg      <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            clean_reg      <= clean_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg       <= len_next;
        pend_type_reg <= pend_type_next;
        pend_len_reg  <= pend_len_next;
        out_type_reg  <= out_type_next;
        out_len_reg   <= out_len_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_len_reg, out_type_reg};
    assign m_axis_tlast  = out_last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(BUFFER_BYTES))
        else $error("fill count beyond store size");

    a_clean_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        clean_reg <= fill_reg)
        else $error("searched span beyond fill count");

    a_idle_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held result left behind at end of byte");

    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RES_CW'(MAX_RESULTS))
        else $error("too many frames for one byte");

endmodule

/* design/length_framed_packet_deframer.sv */
// Length-framed packet deframer, top level.
// Depends on dfr_pkg, dfr_cfg, dfr_front and dfr_back.

// Each received byte enters a four-deep input queue and is then appended to a
// circular store of BUFFER_BYTES bytes (oldest byte overwritten when full),
// which is scanned for frames: start marker, length L, L payload bytes, end
// marker. Every complete frame gives one output request carrying the third
// frame byte and L; tlast marks the last frame found for a byte, at most 42
// per byte. The scan engine reads the store through a single port with a
// registered read; a found frame can wait for the output to accept.
// Bytes already known to hold no start marker are not searched again; only
// a rejected start, a found frame or a new start marker sends the search
// back over the store. The store needs no clearing pass after reset.
// Configuration registers are to be written through the cfg port only while
// the block is idle, which the block does not enforce; cfg_ready is always high.

module length_framed_packet_deframer #(
    parameter int unsigned BUFFER_BYTES = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [7:0] frame_type, [15:8] payload_length
    output logic                        m_axis_tlast,   // last_frame
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dfr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DW-1:0]  cfg_data
);
    import dfr_pkg::*;

    cfg_t cfg;
    rxq_t rxq;
    logic rxq_pop;

    dfr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .rxq           (rxq),
        .rxq_pop       (rxq_pop)
    );

    dfr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .rxq           (rxq),
        .rxq_pop       (rxq_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
